/* rtl/shamh_pkg.sv */
// ----------------------------------------------------------------------------
// shamh_pkg
// types, constants and round functions shared by the sha-256 hasher modules
// ----------------------------------------------------------------------------
package shamh_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_in;
        logic       shift_word;
    } sched_ctl_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       fold;
        logic       reinit;
        logic [5:0] k_idx;
    } core_ctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* rtl/shamh_sched.sv */
// ----------------------------------------------------------------------------
// shamh_sched
// block buffer and message schedule: bytes shift in, words shift out per round
// ----------------------------------------------------------------------------
module shamh_sched (
    input  logic                 clk,
    input  shamh_pkg::sched_ctl_t ctl,
    output shamh_pkg::word_t     w_cur
);
    import shamh_pkg::*;

    logic [15:0][31:0] win_reg;
    logic [15:0][31:0] win_next;
    word_t             w_new;

    assign w_new = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                 + small_sigma1(win_reg[14]);
    assign w_cur = win_reg[0];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift_byte)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctl.byte_in};
        end
        else if (ctl.shift_word)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* rtl/shamh_core.sv */
// ----------------------------------------------------------------------------
// shamh_core
// chaining words and the round unit, one compression round per cycle while step is set
// ----------------------------------------------------------------------------
module shamh_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shamh_pkg::core_ctl_t ctl,
    input  shamh_pkg::word_t     w_cur,
    output logic [7:0][31:0]     chain
);
    import shamh_pkg::*;

    logic [7:0][31:0] chain_reg;
    logic [7:0][31:0] chain_next;
    logic [7:0][31:0] vars_reg;
    logic [7:0][31:0] vars_next;
    word_t            t1;
    word_t            t2;
    word_t            ch;
    word_t            maj;

    assign chain = chain_reg;

    always_comb
    begin
        ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
        t1  = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + ROUND_K[ctl.k_idx] + w_cur;
        t2  = big_sigma0(vars_reg[0]) + maj;

        vars_next  = vars_reg;
        chain_next = chain_reg;
        if (ctl.load)
        begin
            vars_next = chain_reg;
        end
        else if (ctl.step)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
        if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
        end
        else if (ctl.reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = INIT_HASH[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
    end

endmodule

/* rtl/sha256_message_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// sha-256 over a byte stream with padding and an eight-word digest output
// ----------------------------------------------------------------------------
// Each accepted item with a valid byte shifts it into the block; every 64th
// byte starts the compression, which runs one round per cycle through a
// single round unit and then folds into the chaining words, and the block
// takes no item meanwhile. An end item adds the padding bytes (9 to 72 bytes,
// so one or two more compressions) and then holds the eight digest words on
// the output, one per cycle while tready is high, before taking the next
// item.
module sha256_message_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // byte_valid
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast   // last_word
);
    import shamh_pkg::*;

    state_t           state_reg, state_next;
    logic [5:0]       pos_reg, pos_next;
    logic [60:0]      count_reg, count_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [2:0]       oidx_reg, oidx_next;
    logic             pend_reg, pend_next;
    logic             pad_reg, pad_next;
    logic             extra_reg, extra_next;
    logic             final_reg, final_next;

    sched_ctl_t       sctl;
    core_ctl_t        cctl;
    word_t            w_cur;
    logic [7:0][31:0] chain;
    logic [63:0]      len_bits;
    logic [7:0]       len_byte;
    logic             is_len;
    logic             pos_last;

    shamh_sched u_sched (
        .clk   (clk),
        .ctl   (sctl),
        .w_cur (w_cur)
    );

    shamh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .w_cur (w_cur),
        .chain (chain)
    );

    assign len_bits = {count_reg, 3'b000};
    assign len_byte = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
    assign is_len   = pad_reg && !extra_reg && (pos_reg[5:3] == 3'd7);
    assign pos_last = (pos_reg == 6'd63);

    assign m_axis_tdata = {5'b00000, oidx_reg, chain[oidx_reg]};
    assign m_axis_tlast = (oidx_reg == 3'd7);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        rnd_next      = rnd_reg;
        oidx_next     = oidx_reg;
        pend_next     = pend_reg;
        pad_next      = pad_reg;
        extra_next    = extra_reg;
        final_next    = final_reg;
        sctl          = '0;
        cctl          = '0;
        cctl.k_idx    = rnd_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    pend_next = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        sctl.shift_byte = 1'b1;
                        sctl.byte_in    = s_axis_tdata;
                        pos_next        = pos_reg + 6'd1;
                        count_next      = count_reg + 61'd1;
                    end
                    if (s_axis_tuser && pos_last)
                    begin
                        cctl.load  = 1'b1;
                        rnd_next   = '0;
                        state_next = ST_COMP;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                sctl.shift_byte = 1'b1;
                if (!pad_reg)
                begin
                    sctl.byte_in = PAD_MARK;
                    extra_next   = (pos_reg[5:3] == 3'd7) && !pos_last;
                end
                else
                begin
                    sctl.byte_in = is_len ? len_byte : 8'h00;
                    extra_next   = pos_last ? 1'b0 : extra_reg;
                end
                pad_next   = 1'b1;
                final_next = is_len && pos_last;
                pos_next   = pos_reg + 6'd1;
                if (pos_last)
                begin
                    cctl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                cctl.step       = 1'b1;
                sctl.shift_word = 1'b1;
                rnd_next        = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cctl.fold = 1'b1;
                if (final_reg)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        cctl.reinit = 1'b1;
                        count_next  = '0;
                        pos_next    = '0;
                        pend_next   = 1'b0;
                        pad_next    = 1'b0;
                        extra_next  = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            pend_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            extra_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            pend_reg  <= pend_next;
            pad_reg   <= pad_next;
            extra_reg <= extra_next;
            final_reg <= final_next;
        end
    end

endmodule

/* rtl/shamh_checker.sv */
// ----------------------------------------------------------------------------
// shamh_checker
// port-level checks for the sha-256 hasher, bound to the top level
// ----------------------------------------------------------------------------
module shamh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // no item taken while the digest is being delivered
    a_no_accept_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while digest output pending");

    // digest words come out in order
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)))
        else $error("digest word index out of sequence");

    // tlast marks word seven only
    a_last_on_seven: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast not aligned with final digest word");

    // the digest ends after its last word
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output still valid after final digest word");

    // stalled output item holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output item changed while stalled");

endmodule

bind sha256_message_hasher_top shamh_checker u_shamh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/sha256_message_hasher_top_tb.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_top_tb
// self-checking bench for the sha-256 byte stream hasher
// ----------------------------------------------------------------------------
// Messages go in as byte items. Some items carry no byte, and the end mark
// sits either on the last byte or on an item of its own. A bit-exact software
// hash in the bench computes the eight digest words of every closed message
// when its end item is accepted. Each digest item that comes out is compared
// with the oldest pending word. The run starts with a short directed part:
// the empty message, single bytes at both extremes, "abc" and ignored items.
// Short random messages follow in phases of sender gaps and receiver stalls.
// One phase opens with a message of exactly one block and one with a message
// of 56 bytes, whose length field spills into an extra block. One phase holds
// the receiver off long enough to back the hasher up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_message_hasher_top_tb;

    import shamh_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASE_ITEMS      = 4;

    typedef struct {
        logic [7:0] data;
        logic       bval;
        logic       eom;
    } byte_item_t;

    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_rec_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    byte_item_t  pending [$];
    byte_item_t  in_flight;
    digest_rec_t digests [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;
    bit hold_ack       = 1'b0;

    word_t       chain_state [8]  = INIT_HASH;
    word_t       block_words [16];
    logic [5:0]  fill_pos         = '0;
    logic [60:0] byte_total       = '0;

    sha256_message_hasher_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // byte_valid
        .s_axis_tlast  (s_axis_tlast),   // end_of_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] digest_word, [34:32] word_index
        .m_axis_tlast  (m_axis_tlast)    // last_word
    );

    always #CLK_HALF clk = ~clk;

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        word_t s0;
        word_t s1;
        int    j;
        for (j = 0; j < 16; j++)
            w[j] = block_words[j];
        for (j = 16; j < 64; j++)
        begin
            s0   = ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3);
            s1   = ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = w[j-16] + s0 + w[j-7] + s1;
        end
        v = chain_state;
        for (j = 0; j < 64; j++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[j] + w[j];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++)
            chain_state[j] = chain_state[j] + v[j];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * int'(fill_pos[1:0]);
        if (fill_pos[1:0] == 2'd0)
            block_words[fill_pos[5:2]] = word_t'(b) << sh;
        else
            block_words[fill_pos[5:2]] = block_words[fill_pos[5:2]] | (word_t'(b) << sh);
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
            compress_block();
    endtask

    task automatic hash_item(input byte_item_t it);
        logic [63:0] bit_len;
        digest_rec_t rec;
        int          j;
        if (it.bval)
        begin
            absorb_byte(it.data);
            byte_total = byte_total + 61'd1;
        end
        if (it.eom)
        begin
            bit_len = {byte_total, 3'b000};
            absorb_byte(PAD_MARK);
            while (fill_pos != 6'd56)
                absorb_byte(8'h00);
            for (j = 0; j < 8; j++)
                absorb_byte(bit_len[63 - 8 * j -: 8]);
            for (j = 0; j < 8; j++)
            begin
                rec.word = chain_state[j];
                rec.idx  = j[2:0];
                rec.last = (j == 7);
                digests  = {digests, rec};
            end
            chain_state = INIT_HASH;
            byte_total  = '0;
            fill_pos    = '0;
        end
    endtask

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic push_item(input logic [7:0] data, input logic bval, input logic eom);
        byte_item_t it;
        it.data = data;
        it.bval = bval;
        it.eom  = eom;
        pending = {pending, it};
    endtask

    task automatic queue_message(input int len);
        bit end_on_byte;
        int n;
        end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (n = 0; n < len; n++)
        begin
            if (len < 16 && $urandom_range(0, 9) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, end_on_byte && (n == len - 1));
        end
        if (!end_on_byte)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending.size() != 0 || s_axis_tvalid || digests.size() != 0);
    endtask

    task automatic run_phase(input int idle, input int stall, input bit long_hold,
                             input int first_len);
        int count;
        int msgs;
        int len;
        @(negedge clk);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (long_hold)
            hold_req = ~hold_req;
        queue_message(first_len);
        count = first_len;
        msgs  = 1;
        while (count < PHASE_ITEMS || msgs < 2)
        begin
            len = $urandom_range(0, 6);
            queue_message(len);
            count += (len == 0) ? 1 : len;
            msgs++;
        end
        wait_drain();
    endtask

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                hash_item(in_flight);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_flight = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.data;
                    s_axis_tuser  <= in_flight.bval;
                    s_axis_tlast  <= in_flight.eom;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req != hold_ack)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // output side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digests.size() == 0)
                    note_failure($sformatf("unexpected digest item %h last %b",
                                           m_axis_tdata, m_axis_tlast));
                else
                begin
                    digest_rec_t want;
                    want = digests.pop_front();
                    if (m_axis_tdata[31:0] !== want.word || m_axis_tdata[34:32] !== want.idx
                        || m_axis_tlast !== want.last)
                        note_failure($sformatf(
                            "digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                            want.word, want.idx, want.last,
                            m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast));
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        // ignored item, empty message
        push_item(8'ha5, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        // "abc" with the end on the last byte
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // single bytes at both extremes
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        // an ignored item mid-message and a separate end item
        push_item(8'h12, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h34, 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1);
        wait_drain();

        run_phase(0, 0, 1'b1, 64);
        run_phase(49, 0, 1'b0, 2);
        run_phase(0, 49, 1'b0, 56);
        run_phase(15, 15, 1'b0, 5);

        repeat (200) @(posedge clk);
        if (fail_count == 0 && digests.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/shamh_pkg.sv
rtl/shamh_sched.sv
rtl/shamh_core.sv
rtl/sha256_message_hasher_top.sv
rtl/shamh_checker.sv
sim/sha256_message_hasher_top_tb.sv
